### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared constants and controller/datapath handshake types for the
// local minimum probe search.
// ----------------------------------------------------------------------------
package lmps_pkg;

    localparam int MAX_LENGTH_DEF = 4096;
    localparam int VALUE_BITS_DEF = 32;

    // result kind codes
    localparam logic KIND_PROBE  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    // result position select
    localparam logic [1:0] RES_LQ     = 2'd0;
    localparam logic [1:0] RES_UQ     = 2'd1;
    localparam logic [1:0] RES_ANSWER = 2'd2;

    typedef struct packed {
        logic       start;         // load a fresh triple, result probes middle
        logic       cap_mid;       // middle value from reply
        logic       cap_lq;        // lower quarter value from reply
        logic       cap_up;        // upper quarter value from reply
        logic       set_lq;        // latch lower quarter position
        logic       lq_from_left;  // lower quarter coincides with left end
        logic       set_uq;        // latch upper quarter position
        logic       up_from_right; // upper quarter coincides with right end
        logic       go_lower;      // right <= mid, mid <= lower quarter
        logic       go_upper;      // left <= mid, mid <= upper quarter
        logic       go_outer;      // left <= lower quarter, right <= upper quarter
        logic       res_load;
        logic [1:0] res_sel;
        logic       res_kind;
        logic       out_load;
    } lmps_ctrl_t;

    typedef struct packed {
        logic narrow;      // interval too small to split
        logic lq_is_left;
        logic lq_le_mid;
        logic uq_is_right;
        logic up_le_mid;
        logic out_free;
    } lmps_stat_t;

endpackage

### rtl/lmps_if.sv
// ----------------------------------------------------------------------------
// lmps_if
// Valid/ready channels of the local minimum probe search.
// ----------------------------------------------------------------------------
interface lmps_cmd_if #(
    parameter int VALUE_BITS = lmps_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface lmps_res_if #(
    parameter int MAX_LENGTH = lmps_pkg::MAX_LENGTH_DEF
);
    localparam int POS_BITS = $clog2(MAX_LENGTH + 1);

    logic                valid;
    logic                ready;
    logic                kind;
    logic [POS_BITS-1:0] position;

    modport source (output valid, output kind, output position, input ready);
    modport sink   (input valid, input kind, input position, output ready);
endinterface

interface lmps_cfg_if #(
    parameter int MAX_LENGTH = lmps_pkg::MAX_LENGTH_DEF
);
    localparam int POS_BITS = $clog2(MAX_LENGTH + 1);

    logic                valid;
    logic                ready;
    logic [POS_BITS-1:0] seq_length;

    modport source (output valid, output seq_length, input ready);
    modport sink   (input valid, input seq_length, output ready);
endinterface

### rtl/lmps_ctrl.sv
// ----------------------------------------------------------------------------
// lmps_ctrl
// Search sequencer: tracks which reply is expected and steps the datapath
// through the narrowing rounds until a probe or an answer is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    input  lmps_pkg::lmps_stat_t stat,
    output lmps_pkg::lmps_ctrl_t ctrl
);
    import lmps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ST1   = 3'd2;
    localparam logic [2:0] S_ST2   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_LQ   = 2'd2;
    localparam logic [1:0] PH_UQ   = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_command == CMD_START)
                    begin
                        ctrl.start = 1'b1;
                        phase_next = PH_MID;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_MID:
                            begin
                                ctrl.cap_mid = 1'b1;
                                state_next   = S_ROUND;
                            end
                            PH_LQ:
                            begin
                                ctrl.cap_lq = 1'b1;
                                state_next  = S_ST1;
                            end
                            PH_UQ:
                            begin
                                ctrl.cap_up = 1'b1;
                                state_next  = S_ST2;
                            end
                            default:
                            begin
                                // reply with no search running: dropped
                            end
                        endcase
                    end
                end
            end
            S_ROUND:
            begin
                if (stat.narrow)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_sel  = RES_ANSWER;
                    ctrl.res_kind = KIND_ANSWER;
                    phase_next    = PH_IDLE;
                    state_next    = S_EMIT;
                end
                else
                begin
                    ctrl.set_lq = 1'b1;
                    if (stat.lq_is_left)
                    begin
                        ctrl.lq_from_left = 1'b1;
                        state_next        = S_ST1;
                    end
                    else
                    begin
                        ctrl.res_load = 1'b1;
                        ctrl.res_sel  = RES_LQ;
                        ctrl.res_kind = KIND_PROBE;
                        phase_next    = PH_LQ;
                        state_next    = S_EMIT;
                    end
                end
            end
            S_ST1:
            begin
                if (stat.lq_le_mid)
                begin
                    ctrl.go_lower = 1'b1;
                    state_next    = S_ROUND;
                end
                else
                begin
                    ctrl.set_uq = 1'b1;
                    if (stat.uq_is_right)
                    begin
                        ctrl.up_from_right = 1'b1;
                        state_next         = S_ST2;
                    end
                    else
                    begin
                        ctrl.res_load = 1'b1;
                        ctrl.res_sel  = RES_UQ;
                        ctrl.res_kind = KIND_PROBE;
                        phase_next    = PH_UQ;
                        state_next    = S_EMIT;
                    end
                end
            end
            S_ST2:
            begin
                if (stat.up_le_mid)
                begin
                    ctrl.go_upper = 1'b1;
                end
                else
                begin
                    ctrl.go_outer = 1'b1;
                end
                state_next = S_ROUND;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `ASSERT_NEXT(a_idle_reply_dropped, in_fire && (in_command == CMD_REPLY) && (phase_reg == PH_IDLE), state_reg == S_IDLE, "reply while idle started work")
    `ASSERT_NEXT(a_start_probes_mid, in_fire && (in_command == CMD_START), (state_reg == S_EMIT) && (phase_reg == PH_MID), "start did not queue middle probe")
    `ASSERT_NEXT(a_answer_ends_search, (state_reg == S_ROUND) && stat.narrow, (state_reg == S_EMIT) && (phase_reg == PH_IDLE), "answer did not end search")
    `ASSERT_NEXT(a_emit_waits, (state_reg == S_EMIT) && !stat.out_free, state_reg == S_EMIT, "result dropped while output busy")

endmodule

### rtl/lmps_dp.sv
// ----------------------------------------------------------------------------
// lmps_dp
// Search datapath: the left/middle/right triple, quarter points, value
// comparisons, answer selection and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmps_dp #(
    parameter  int MAX_LENGTH = lmps_pkg::MAX_LENGTH_DEF,
    parameter  int VALUE_BITS = lmps_pkg::VALUE_BITS_DEF,
    localparam int POS_BITS   = $clog2(MAX_LENGTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [POS_BITS-1:0]          cfg_seq_length,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  lmps_pkg::lmps_ctrl_t         ctrl,
    output lmps_pkg::lmps_stat_t         stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [POS_BITS-1:0]          out_position
);
    import lmps_pkg::*;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_THREE = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_MAX   = POS_BITS'(MAX_LENGTH);

    logic [POS_BITS-1:0]          seq_length_reg;
    logic [POS_BITS-1:0]          left_pos_reg, mid_pos_reg, right_pos_reg;
    logic [POS_BITS-1:0]          lq_pos_reg, uq_pos_reg;
    logic signed [VALUE_BITS-1:0] left_val_reg, mid_val_reg, right_val_reg;
    logic signed [VALUE_BITS-1:0] lq_val_reg, up_val_reg;
    logic                         res_kind_reg;
    logic [POS_BITS-1:0]          res_pos_reg;
    logic                         out_valid_reg, out_kind_reg;
    logic [POS_BITS-1:0]          out_pos_reg;

    logic [POS_BITS-1:0] len_clamped;
    logic [POS_BITS:0]   start_sum;
    logic [POS_BITS-1:0] start_mid;
    logic [POS_BITS:0]   lq_sum, uq_sum;
    logic [POS_BITS-1:0] lq_half, uq_half, lq_calc, uq_calc;
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] answer_pos;
    logic [POS_BITS-1:0] res_pos_sel;
    logic                out_free;

    // start: clamp length, middle of [1, n]
    always_comb
    begin
        if (seq_length_reg < POS_THREE)
        begin
            len_clamped = POS_THREE;
        end
        else if (seq_length_reg > POS_MAX)
        begin
            len_clamped = POS_MAX;
        end
        else
        begin
            len_clamped = seq_length_reg;
        end
    end

    assign start_sum = {1'b0, len_clamped} + (POS_BITS+1)'(1);
    assign start_mid = start_sum[POS_BITS:1];

    // quarter points, pushed off the middle when the halving lands on it
    assign lq_sum  = {1'b0, left_pos_reg} + {1'b0, mid_pos_reg};
    assign lq_half = lq_sum[POS_BITS:1];
    assign lq_calc = (lq_half == mid_pos_reg) ? (mid_pos_reg - POS_ONE) : lq_half;
    assign uq_sum  = {1'b0, mid_pos_reg} + {1'b0, right_pos_reg};
    assign uq_half = uq_sum[POS_BITS:1];
    assign uq_calc = (uq_half == mid_pos_reg) ? (mid_pos_reg + POS_ONE) : uq_half;

    assign span = right_pos_reg - left_pos_reg;

    // final pick; a tie with the middle keeps the middle, a left/right tie picks left
    always_comb
    begin
        if ((mid_val_reg < left_val_reg) && (mid_val_reg < right_val_reg))
        begin
            answer_pos = mid_pos_reg;
        end
        else if (left_val_reg < mid_val_reg)
        begin
            answer_pos = left_pos_reg;
        end
        else if (right_val_reg < mid_val_reg)
        begin
            answer_pos = right_pos_reg;
        end
        else
        begin
            answer_pos = mid_pos_reg;
        end
    end

    always_comb
    begin
        case (ctrl.res_sel)
            RES_LQ:     res_pos_sel = lq_calc;
            RES_UQ:     res_pos_sel = uq_calc;
            RES_ANSWER: res_pos_sel = answer_pos;
            default:    res_pos_sel = answer_pos;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    assign stat.narrow      = (right_pos_reg < left_pos_reg) || (span < POS_THREE);
    assign stat.lq_is_left  = (lq_calc == left_pos_reg);
    assign stat.lq_le_mid   = (lq_val_reg <= mid_val_reg);
    assign stat.uq_is_right = (uq_calc == right_pos_reg);
    assign stat.up_le_mid   = (up_val_reg <= mid_val_reg);
    assign stat.out_free    = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= POS_THREE;
            left_pos_reg   <= POS_ONE;
            mid_pos_reg    <= '0;
            right_pos_reg  <= '0;
            lq_pos_reg     <= '0;
            uq_pos_reg     <= '0;
            left_val_reg   <= VAL_MAX;
            mid_val_reg    <= '0;
            right_val_reg  <= VAL_MAX;
            lq_val_reg     <= '0;
            up_val_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seq_length_reg <= cfg_seq_length;
            end

            if (ctrl.start)
            begin
                left_pos_reg  <= POS_ONE;
                right_pos_reg <= len_clamped;
                mid_pos_reg   <= start_mid;
                left_val_reg  <= VAL_MAX;
                right_val_reg <= VAL_MAX;
            end
            if (ctrl.cap_mid)
            begin
                mid_val_reg <= in_value;
            end
            if (ctrl.cap_lq)
            begin
                lq_val_reg <= in_value;
            end
            if (ctrl.cap_up)
            begin
                up_val_reg <= in_value;
            end
            if (ctrl.set_lq)
            begin
                lq_pos_reg <= lq_calc;
                if (ctrl.lq_from_left)
                begin
                    lq_val_reg <= left_val_reg;
                end
            end
            if (ctrl.set_uq)
            begin
                uq_pos_reg <= uq_calc;
                if (ctrl.up_from_right)
                begin
                    up_val_reg <= right_val_reg;
                end
            end
            if (ctrl.go_lower)
            begin
                right_pos_reg <= mid_pos_reg;
                right_val_reg <= mid_val_reg;
                mid_pos_reg   <= lq_pos_reg;
                mid_val_reg   <= lq_val_reg;
            end
            if (ctrl.go_upper)
            begin
                left_pos_reg <= mid_pos_reg;
                left_val_reg <= mid_val_reg;
                mid_pos_reg  <= uq_pos_reg;
                mid_val_reg  <= up_val_reg;
            end
            if (ctrl.go_outer)
            begin
                left_pos_reg  <= lq_pos_reg;
                left_val_reg  <= lq_val_reg;
                right_pos_reg <= uq_pos_reg;
                right_val_reg <= up_val_reg;
            end

            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result and output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            res_kind_reg <= KIND_PROBE;
            res_pos_reg  <= start_mid;
        end
        else if (ctrl.res_load)
        begin
            res_kind_reg <= ctrl.res_kind;
            res_pos_reg  <= res_pos_sel;
        end
        if (ctrl.out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_pos_reg  <= res_pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_position = out_pos_reg;

    `ASSERT_IMPLIES(a_out_pos_nonzero, out_valid_reg, out_pos_reg != '0, "result position is zero")
    `ASSERT_IMPLIES(a_load_when_free, ctrl.out_load, out_free, "output overwritten before transfer")
    `ASSERT_NEXT(a_answer_from_triple, ctrl.res_load && (ctrl.res_sel == RES_ANSWER), (res_pos_reg == $past(left_pos_reg)) || (res_pos_reg == $past(mid_pos_reg)) || (res_pos_reg == $past(right_pos_reg)), "answer not from triple")

endmodule

### rtl/local_minimum_probe_search.sv
// ----------------------------------------------------------------------------
// local_minimum_probe_search
// Start: the middle position is the first probe, sent when the output is free.
// Reply: sequencer steps through round check, lower and upper quarter states
// until the next probe or the answer is loaded, then waits for a free output.
// A new item is taken the cycle after the result enters the output register.
// rst_n (async, active low) idles the search; length register resets to 3.
// ----------------------------------------------------------------------------
module local_minimum_probe_search #(
    parameter int MAX_LENGTH = lmps_pkg::MAX_LENGTH_DEF,
    parameter int VALUE_BITS = lmps_pkg::VALUE_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    lmps_cmd_if.sink   cmd,
    lmps_res_if.source res,
    lmps_cfg_if.sink   cfg
);
    import lmps_pkg::*;

    lmps_ctrl_t ctrl;
    lmps_stat_t stat;
    logic       in_ready;

    assign cmd.ready = in_ready;
    assign cfg.ready = 1'b1;

    lmps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_command (cmd.command),
        .in_ready   (in_ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    lmps_dp #(
        .MAX_LENGTH (MAX_LENGTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg.valid),
        .cfg_seq_length (cfg.seq_length),
        .in_value       (cmd.value),
        .ctrl           (ctrl),
        .stat           (stat),
        .out_ready      (res.ready),
        .out_valid      (res.valid),
        .out_kind       (res.kind),
        .out_position   (res.position)
    );

endmodule
